>>> rtl/rewg_pkg.sv
// rewg_pkg: shared types and constants for the RSSI EWMA hysteresis gate.
// No dependencies; imported by rewg_cfg, rewg_core and the top level.
package rewg_pkg;

    localparam int Q4_FRAC   = 4;
    localparam int AVG_W     = 12;
    localparam int DBM_W     = 8;
    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int SHIFT_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_SHIFT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LEVEL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_OPEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_WINDOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_CAP     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_DELAY  = 3'd6;

    localparam logic [SHIFT_W-1:0]       RST_SMOOTH_SHIFT = 4'd2;
    localparam logic signed [DBM_W-1:0]  RST_OPEN_LEVEL   = -8'sd60;
    localparam logic signed [DBM_W-1:0]  RST_CLOSE_LEVEL  = -8'sd75;
    localparam logic [DBM_W-1:0]         RST_RISE_OPEN    = 8'd0;
    localparam logic [MS_W-1:0]          RST_RISE_WINDOW  = 16'd1000;
    localparam logic [MS_W-1:0]          RST_HOLD_CAP     = 16'd0;
    localparam logic [MS_W-1:0]          RST_CLOSE_DELAY  = 16'd2000;

    typedef struct packed {
        logic [SHIFT_W-1:0]      smoothing_shift;
        logic signed [DBM_W-1:0] open_level_dbm;
        logic signed [DBM_W-1:0] close_level_dbm;
        logic [DBM_W-1:0]        rise_open_db;
        logic [MS_W-1:0]         rise_window_ms;
        logic [MS_W-1:0]         hold_cap_ms;
        logic [MS_W-1:0]         close_delay_ms;
    } t_cfg;

    typedef struct packed {
        logic                    mode;
        logic                    sample_valid;
        logic signed [DBM_W-1:0] rx_dbm;
        logic [TIME_W-1:0]       time_ms;
    } t_item;

    typedef struct packed {
        logic                    gate_open;
        logic                    was_capped;
        logic signed [DBM_W-1:0] level_dbm;
    } t_res;

endpackage

>>> rtl/rewg_smp_if.sv
// rewg_smp_if: sample/hold-event channel, valid/ready with payload fields.
// Depends on nothing.
interface rewg_smp_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic        sample_valid;
    logic signed [7:0] rx_dbm;
    logic [31:0] time_ms;

    modport source (output valid, output mode, output sample_valid,
                    output rx_dbm, output time_ms, input ready);
    modport sink   (input valid, input mode, input sample_valid,
                    input rx_dbm, input time_ms, output ready);
endinterface

>>> rtl/rewg_res_if.sv
// rewg_res_if: result channel, valid/ready with gate state payload.
// Depends on nothing.
interface rewg_res_if;
    logic              valid;
    logic              ready;
    logic              gate_open;
    logic              was_capped;
    logic signed [7:0] level_dbm;

    modport source (output valid, output gate_open, output was_capped,
                    output level_dbm, input ready);
    modport sink   (input valid, input gate_open, input was_capped,
                    input level_dbm, output ready);
endinterface

>>> rtl/rewg_cfg.sv
// rewg_cfg: configuration register file, written by index.
// Depends on rewg_pkg.
module rewg_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rewg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rewg_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output rewg_pkg::t_cfg                   o_cfg
);
    import rewg_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smoothing_shift <= RST_SMOOTH_SHIFT;
            r_cfg.open_level_dbm  <= RST_OPEN_LEVEL;
            r_cfg.close_level_dbm <= RST_CLOSE_LEVEL;
            r_cfg.rise_open_db    <= RST_RISE_OPEN;
            r_cfg.rise_window_ms  <= RST_RISE_WINDOW;
            r_cfg.hold_cap_ms     <= RST_HOLD_CAP;
            r_cfg.close_delay_ms  <= RST_CLOSE_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SMOOTH_SHIFT: r_cfg.smoothing_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_OPEN_LEVEL:   r_cfg.open_level_dbm  <= $signed(i_cfg_data[DBM_W-1:0]);
                CFG_CLOSE_LEVEL:  r_cfg.close_level_dbm <= $signed(i_cfg_data[DBM_W-1:0]);
                CFG_RISE_OPEN:    r_cfg.rise_open_db    <= i_cfg_data[DBM_W-1:0];
                CFG_RISE_WINDOW:  r_cfg.rise_window_ms  <= i_cfg_data[MS_W-1:0];
                CFG_HOLD_CAP:     r_cfg.hold_cap_ms     <= i_cfg_data[MS_W-1:0];
                CFG_CLOSE_DELAY:  r_cfg.close_delay_ms  <= i_cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/rewg_core.sv
// rewg_core: gate state registers and the single-pass update for one item.
// Depends on rewg_pkg; result is combinational from the registered item.
module rewg_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  rewg_pkg::t_item   i_item,
    input  rewg_pkg::t_cfg    i_cfg,
    output rewg_pkg::t_res    o_res
);
    import rewg_pkg::*;

    localparam int DIFF_W = AVG_W + SHIFT_W + 2;

    logic [AVG_W-1:0]  r_avg, n_avg;
    logic              r_primed, n_primed;
    logic [AVG_W-1:0]  r_mid_q4, n_mid_q4;
    logic [TIME_W-1:0] r_mid_time, n_mid_time;
    logic              r_mid_valid, n_mid_valid;
    logic [AVG_W-1:0]  r_old_q4, n_old_q4;
    logic [TIME_W-1:0] r_old_time, n_old_time;
    logic              r_old_valid, n_old_valid;
    logic              r_open, n_open;
    logic              r_below, n_below;
    logic [TIME_W-1:0] r_below_start, n_below_start;
    logic              r_hold, n_hold;
    logic [TIME_W-1:0] r_hold_start, n_hold_start;
    logic              r_capped, n_capped;

    logic [AVG_W-1:0]  s_q4;
    logic [DIFF_W-1:0] diff, bias, biased, step;
    logic [AVG_W-1:0]  avg_upd;
    logic [TIME_W-1:0] now, dt_mid, dt_old, dt_hold, dt_below;
    logic              ref_shift;
    logic [AVG_W-1:0]  ref_old_q4;
    logic [TIME_W-1:0] ref_old_time;
    logic              ref_old_valid;
    logic [AVG_W:0]    rise_diff;
    logic [AVG_W-1:0]  open_q4, close_q4;
    logic              lvl_open, rise_open, cap_open;
    logic [AVG_W-1:0]  lvl_tmp;

    assign now     = i_item.time_ms;
    assign s_q4    = {i_item.rx_dbm, {Q4_FRAC{1'b0}}};
    assign open_q4 = {i_cfg.open_level_dbm, {Q4_FRAC{1'b0}}};
    assign close_q4 = {i_cfg.close_level_dbm, {Q4_FRAC{1'b0}}};

    // step = (s - avg) / 2^shift, truncated toward zero
    assign diff   = {{(DIFF_W-AVG_W){s_q4[AVG_W-1]}}, s_q4}
                  - {{(DIFF_W-AVG_W){r_avg[AVG_W-1]}}, r_avg};
    assign bias   = diff[DIFF_W-1] ? ((DIFF_W'(1) << i_cfg.smoothing_shift) - DIFF_W'(1))
                                   : '0;
    assign biased = diff + bias;
    assign step   = DIFF_W'($signed(biased) >>> i_cfg.smoothing_shift);
    assign avg_upd = r_primed ? (r_avg + step[AVG_W-1:0]) : s_q4;

    // mid point ages into the old point once half a window old
    assign ref_shift     = r_mid_valid
                         && (dt_mid >= {17'd0, i_cfg.rise_window_ms[MS_W-1:1]});
    assign ref_old_q4    = ref_shift ? r_mid_q4 : r_old_q4;
    assign ref_old_time  = ref_shift ? r_mid_time : r_old_time;
    assign ref_old_valid = ref_shift || r_old_valid;

    assign dt_mid   = now - r_mid_time;
    assign dt_old   = now - ref_old_time;
    assign dt_hold  = now - r_hold_start;
    assign dt_below = now - r_below_start;
    assign rise_diff = {avg_upd[AVG_W-1], avg_upd} - {ref_old_q4[AVG_W-1], ref_old_q4};

    assign lvl_open  = $signed(avg_upd) >= $signed(open_q4);
    assign rise_open = (i_cfg.rise_open_db != '0) && ref_old_valid
                     && (dt_old <= {15'd0, i_cfg.rise_window_ms, 1'b0})
                     && ($signed({rise_diff[AVG_W], rise_diff})
                         >= $signed({2'b00, i_cfg.rise_open_db, {Q4_FRAC{1'b0}}}))
                     && ($signed(avg_upd) > $signed(close_q4));
    assign cap_open  = r_hold && (i_cfg.hold_cap_ms != '0)
                     && (dt_hold >= {16'd0, i_cfg.hold_cap_ms});

    always_comb begin
        n_avg         = r_avg;
        n_primed      = r_primed;
        n_mid_q4      = r_mid_q4;
        n_mid_time    = r_mid_time;
        n_mid_valid   = r_mid_valid;
        n_old_q4      = r_old_q4;
        n_old_time    = r_old_time;
        n_old_valid   = r_old_valid;
        n_open        = r_open;
        n_below       = r_below;
        n_below_start = r_below_start;
        n_hold        = r_hold;
        n_hold_start  = r_hold_start;
        n_capped      = r_capped;
        if (i_item.mode) begin
            n_hold       = 1'b1;
            n_capped     = 1'b0;
            n_hold_start = now;
        end else if (i_item.sample_valid) begin
            n_avg    = avg_upd;
            n_primed = 1'b1;
            if (!r_mid_valid) begin
                n_mid_q4    = avg_upd;
                n_mid_time  = now;
                n_mid_valid = 1'b1;
            end else if (ref_shift) begin
                n_old_q4    = r_mid_q4;
                n_old_time  = r_mid_time;
                n_old_valid = 1'b1;
                n_mid_q4    = avg_upd;
                n_mid_time  = now;
            end
            if (!r_open) begin
                if (!lvl_open && !rise_open && cap_open) begin
                    n_capped = 1'b1;
                end
                if (lvl_open || rise_open || cap_open) begin
                    n_open  = 1'b1;
                    n_below = 1'b0;
                    n_hold  = 1'b0;
                end
            end else if ($signed(avg_upd) <= $signed(close_q4)) begin
                if (!r_below) begin
                    n_below       = 1'b1;
                    n_below_start = now;
                end else if (dt_below >= {16'd0, i_cfg.close_delay_ms}) begin
                    n_open  = 1'b0;
                    n_below = 1'b0;
                end
            end else begin
                n_below = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg         <= '0;
            r_primed      <= 1'b0;
            r_mid_q4      <= '0;
            r_mid_time    <= '0;
            r_mid_valid   <= 1'b0;
            r_old_q4      <= '0;
            r_old_time    <= '0;
            r_old_valid   <= 1'b0;
            r_open        <= 1'b0;
            r_below       <= 1'b0;
            r_below_start <= '0;
            r_hold        <= 1'b0;
            r_hold_start  <= '0;
            r_capped      <= 1'b0;
        end else if (i_fire) begin
            r_avg         <= n_avg;
            r_primed      <= n_primed;
            r_mid_q4      <= n_mid_q4;
            r_mid_time    <= n_mid_time;
            r_mid_valid   <= n_mid_valid;
            r_old_q4      <= n_old_q4;
            r_old_time    <= n_old_time;
            r_old_valid   <= n_old_valid;
            r_open        <= n_open;
            r_below       <= n_below;
            r_below_start <= n_below_start;
            r_hold        <= n_hold;
            r_hold_start  <= n_hold_start;
            r_capped      <= n_capped;
        end
    end

    // level = avg / 16 toward zero
    assign lvl_tmp = n_avg + {{(AVG_W-Q4_FRAC){1'b0}}, {Q4_FRAC{n_avg[AVG_W-1]}}};

    assign o_res.gate_open  = n_open;
    assign o_res.was_capped = n_capped;
    assign o_res.level_dbm  = $signed(lvl_tmp[AVG_W-1:Q4_FRAC]);

endmodule

>>> rtl/rssi_ewma_hysteresis_gate.sv
// rssi_ewma_hysteresis_gate: top level; input register, core update, result register.
// The core result is combinational from the input register; the result register captures it when the core fires.
// Throughput one beat per cycle while o_res.ready is high; the result register stalls on o_res.ready.
// The input register refills in the same cycle that it hands its beat on.
// Synchronous active-low reset clears all gate state and loads register defaults.
// Depends on rewg_pkg, rewg_smp_if, rewg_res_if, rewg_cfg, rewg_core.
module rssi_ewma_hysteresis_gate (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rewg_smp_if.sink                        i_smp,
    rewg_res_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [rewg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rewg_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import rewg_pkg::*;

    t_cfg  cfg;
    t_item r_in;
    logic  r_in_vld;
    t_res  r_out;
    logic  r_out_vld;
    t_res  res;
    logic  fire;

    assign fire        = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_smp.ready = !r_in_vld || fire;

    rewg_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rewg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_smp.ready) begin
                r_in_vld <= i_smp.valid;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_in.mode         <= i_smp.mode;
            r_in.sample_valid <= i_smp.sample_valid;
            r_in.rx_dbm       <= i_smp.rx_dbm;
            r_in.time_ms      <= i_smp.time_ms;
        end
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.gate_open  = r_out.gate_open;
    assign o_res.was_capped = r_out.was_capped;
    assign o_res.level_dbm  = r_out.level_dbm;

endmodule

>>> rtl/rewg_chk.sv
// rewg_chk: port-level checker for the gate, attached by bind.
// Depends on rssi_ewma_hysteresis_gate port names only.
module rewg_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_gate_open,
    input logic       i_was_capped,
    input logic [7:0] i_level_dbm
);
    logic r_seen;
    logic r_prev_capped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen        <= 1'b0;
            r_prev_capped <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen        <= 1'b1;
            r_prev_capped <= i_was_capped;
        end
    end

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_gate_open) && $stable(i_was_capped)
            && $stable(i_level_dbm))
        else $error("stalled result beat changed");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |-> ##2 i_out_valid)
        else $error("result beat missing two cycles after input beat");

    a_cap_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && r_seen && i_was_capped && !r_prev_capped
            |-> i_gate_open)
        else $error("capped flag set without open gate");

endmodule

bind rssi_ewma_hysteresis_gate rewg_chk u_rewg_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_gate_open  (o_res.gate_open),
    .i_was_capped (o_res.was_capped),
    .i_level_dbm  (o_res.level_dbm)
);
